[src/jacobi_stencil_solver_core_defines.svh]
// ----------------------------------------------------------------------------
// Jacobi stencil solver assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef JACOBI_STENCIL_SOLVER_CORE_DEFINES_SVH
`define JACOBI_STENCIL_SOLVER_CORE_DEFINES_SVH

// expr must never hold
`define JSS_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("jss: %s violated", "name");

// ante implies cons in the next cycle
`define JSS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jss: %s violated", "name");

`endif

[src/jss_pkg.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil solver package
// Grid geometry, fixed-point constants, command codes and the
// controller/datapath interface types.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IDX_W      = $clog2(CELLS);
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int RES_W      = 63;
  localparam int ITER_W     = 16;
  localparam int GRID_W     = 6;
  localparam int ADDR_W     = 6;
  localparam int PDATA_W    = 64;

  localparam logic [RES_W-1:0] MAX63 = {RES_W{1'b1}};

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_MAX_ITER  = 3'd0;
  localparam logic [2:0] REG_CHK_INT   = 3'd1;
  localparam logic [2:0] REG_TOL       = 3'd2;
  localparam logic [2:0] REG_GRID_W    = 3'd3;
  localparam logic [2:0] REG_GRID_H    = 3'd4;

  // stencil operand read phase of one cell
  typedef enum logic [2:0] {
    PH_CENTER,
    PH_LEFT,
    PH_RIGHT,
    PH_DOWN,
    PH_UP
  } phase_e;

  typedef struct packed {
    logic [ITER_W-1:0] max_iter;
    logic [ITER_W-1:0] chk_int;
    logic [RES_W-1:0]  tol;
    logic [GRID_W-1:0] grid_w;
    logic [GRID_W-1:0] grid_h;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  ld_idx;
    phase_e            phase;
    logic              issue;
    logic              nb_en;
    logic              clr_acc;
    logic              sum_clr;
    logic              div_start;
    logic              res_sq;
    logic              res_add;
    logic              copy_rd;
    logic              load_we;
    logic              zero_clr;
    logic              res_we;
    logic              push_rd;
    logic              push_solve;
    logic              rd_inside;
    logic [ITER_W-1:0] last_iter;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic sum_below;
    logic out_free;
  } dp_sts_t;

  function automatic logic [IDX_W-1:0] cell_idx(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return IDX_W'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

endpackage

[src/jss_div.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil solver divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward
// zero, saturated to 32-bit signed. Zero divisor saturates at once (0/0 = 0).
// ----------------------------------------------------------------------------
module jss_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [jss_pkg::ACC_W-1:0] dvd_i,
  input  logic signed [jss_pkg::DATA_W-1:0] dvs_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic        [jss_pkg::DATA_W-1:0] quo_o,
  output logic                             zero_o
);
  import jss_pkg::*;

  localparam int MAG_W = ACC_W - 1;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'({1'b1, {(DATA_W-1){1'b0}}});

  logic              busy_q, done_q, zero_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, dmag_q, res_q;
  logic [MAG_W-1:0]  dvd_q, quo_q;

  logic [ACC_W-1:0]  dvd_abs;
  logic [DATA_W-1:0] dvs_abs;
  logic [DATA_W:0]   rem_sh, rem_sub;
  logic              ge;
  logic [MAG_W-1:0]  quo_n, quo_neg;
  logic [DATA_W-1:0] sat_res;

  assign dvd_abs = dvd_i[ACC_W-1] ? ACC_W'(-dvd_i) : ACC_W'(dvd_i);
  assign dvs_abs = dvs_i[DATA_W-1] ? DATA_W'(-dvs_i) : DATA_W'(dvs_i);
  assign rem_sh  = {rem_q, dvd_q[MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh - {1'b0, dmag_q};
  assign quo_n   = {quo_q[MAG_W-2:0], ge};
  assign quo_neg = MAG_W'(-quo_n);

  always_comb begin
    if (!neg_q) begin
      sat_res = (quo_n > POS_LIM) ? {1'b0, {(DATA_W-1){1'b1}}} : quo_n[DATA_W-1:0];
    end else begin
      sat_res = (quo_n > NEG_LIM) ? {1'b1, {(DATA_W-1){1'b0}}} : quo_neg[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        zero_q <= (dvs_i == '0);
        if (dvs_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(MAG_W - 1);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dvd_abs[MAG_W-1:0];
      dmag_q <= dvs_abs;
      neg_q  <= dvd_i[ACC_W-1] ^ dvs_i[DATA_W-1];
      rem_q  <= '0;
      quo_q  <= '0;
      if (dvd_i > 0) begin
        res_q <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (dvd_i < 0) begin
        res_q <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= quo_n;
      dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        res_q <= sat_res;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = res_q;
  assign zero_o = zero_q;

endmodule

[src/jss_ctrl.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil solver controller
// Item intake, grid walk, sweep/check/final pass sequencing and result push.
// ----------------------------------------------------------------------------
module jss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jss_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [4:0]        col_i,
  input  logic [4:0]        row_i,
  input  jss_pkg::dp_sts_t  sts_i,
  output jss_pkg::dp_cmd_t  cmd_o
);
  import jss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_RD_PUSH, ST_S_INIT, ST_ISSUE, ST_WAIT,
    ST_DIV_GO, ST_DIV_WAIT, ST_RES_SQ, ST_RES_ADD, ST_COPY, ST_COPY_END,
    ST_PASS_END, ST_S_PUSH
  } state_e;

  state_e            state_q;
  phase_e            phase_q;
  logic              wait_q, res_pass_q, final_q, rd_inside_q;
  logic [COL_W-1:0]  col_q, wm1;
  logic [ROW_W-1:0]  row_q, hm1;
  logic [ITER_W-1:0] iter_q, chk_q, last_iter_q;

  logic              accept, inside_in, last_cell, do_check;
  logic [ITER_W:0]   iter_n, chk_n;
  logic              nb_en;

  // clamp grid size to 1..MAX
  always_comb begin
    if (cfg_i.grid_w == '0) begin
      wm1 = '0;
    end else if (int'(cfg_i.grid_w) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(cfg_i.grid_w - 1'b1);
    end
    if (cfg_i.grid_h == '0) begin
      hm1 = '0;
    end else if (int'(cfg_i.grid_h) > MAX_HEIGHT) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(cfg_i.grid_h - 1'b1);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign inside_in  = (int'(col_i) < MAX_WIDTH) && (int'(row_i) < MAX_HEIGHT);
  assign last_cell  = (col_q == wm1) && (row_q == hm1);
  assign iter_n     = {1'b0, iter_q} + 1'b1;
  assign chk_n      = ({1'b0, chk_q} + 1'b1 == {1'b0, cfg_i.chk_int}) ? '0
                                                                    : {1'b0, chk_q} + 1'b1;
  // residual check when iter % interval == 0, first sweep excluded
  assign do_check   = (iter_q != '0) && (cfg_i.chk_int != '0) && (chk_q == '0);

  always_comb begin
    unique case (phase_q)
      PH_CENTER: nb_en = 1'b1;
      PH_LEFT:   nb_en = (col_q != '0);
      PH_RIGHT:  nb_en = (col_q != wm1);
      PH_DOWN:   nb_en = (row_q != '0);
      PH_UP:     nb_en = (row_q != hm1);
      default:   nb_en = 1'b0;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.idx        = cell_idx(row_q, col_q);
    cmd_o.ld_idx     = cell_idx(ROW_W'(row_i), COL_W'(col_i));
    cmd_o.phase      = (state_q == ST_ISSUE) ? phase_q : PH_CENTER;
    cmd_o.issue      = (state_q == ST_ISSUE);
    cmd_o.nb_en      = nb_en;
    cmd_o.clr_acc    = (state_q == ST_ISSUE) && (phase_q == PH_CENTER);
    cmd_o.sum_clr    = cmd_o.clr_acc && res_pass_q && (row_q == '0) && (col_q == '0);
    cmd_o.div_start  = (state_q == ST_DIV_GO);
    cmd_o.res_sq     = (state_q == ST_RES_SQ);
    cmd_o.res_add    = (state_q == ST_RES_ADD);
    cmd_o.copy_rd    = (state_q == ST_COPY);
    cmd_o.load_we    = accept && (cmd_i == CMD_LOAD) && inside_in;
    cmd_o.zero_clr   = (state_q == ST_S_INIT);
    cmd_o.res_we     = (state_q == ST_PASS_END) && final_q;
    cmd_o.push_rd    = (state_q == ST_RD_PUSH) && sts_i.out_free;
    cmd_o.push_solve = (state_q == ST_S_PUSH) && sts_i.out_free;
    cmd_o.rd_inside  = rd_inside_q;
    cmd_o.last_iter  = last_iter_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_CENTER;
      wait_q      <= 1'b0;
      res_pass_q  <= 1'b0;
      final_q     <= 1'b0;
      rd_inside_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      iter_q      <= '0;
      chk_q       <= '0;
      last_iter_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i == CMD_READ) begin
            col_q       <= COL_W'(col_i);
            row_q       <= ROW_W'(row_i);
            rd_inside_q <= inside_in;
            state_q     <= ST_RD_WAIT;
          end else if (accept && cmd_i == CMD_SOLVE) begin
            state_q <= ST_S_INIT;
          end
        end
        ST_RD_WAIT: state_q <= ST_RD_PUSH;
        ST_RD_PUSH: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_S_INIT: begin
          last_iter_q <= cfg_i.max_iter;
          iter_q      <= '0;
          chk_q       <= '0;
          col_q       <= '0;
          row_q       <= '0;
          phase_q     <= PH_CENTER;
          res_pass_q  <= (cfg_i.max_iter == '0);
          final_q     <= 1'b1;
          state_q     <= ST_ISSUE;
        end
        ST_ISSUE: begin
          unique case (phase_q)
            PH_CENTER: phase_q <= PH_LEFT;
            PH_LEFT:   phase_q <= PH_RIGHT;
            PH_RIGHT:  phase_q <= PH_DOWN;
            PH_DOWN:   phase_q <= PH_UP;
            default: begin
              wait_q  <= 1'b0;
              state_q <= ST_WAIT;
            end
          endcase
        end
        ST_WAIT: begin
          wait_q <= 1'b1;
          if (wait_q) begin
            state_q <= res_pass_q ? ST_RES_SQ : ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_RES_SQ: state_q <= ST_RES_ADD;
        ST_DIV_WAIT, ST_RES_ADD: begin
          if (state_q == ST_RES_ADD || sts_i.div_done) begin
            phase_q <= PH_CENTER;
            if (last_cell) begin
              col_q   <= '0;
              row_q   <= '0;
              state_q <= res_pass_q ? ST_PASS_END : ST_COPY;
            end else begin
              if (col_q == wm1) begin
                col_q <= '0;
                row_q <= row_q + 1'b1;
              end else begin
                col_q <= col_q + 1'b1;
              end
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_COPY: begin
          if (last_cell) begin
            col_q   <= '0;
            row_q   <= '0;
            state_q <= ST_COPY_END;
          end else if (col_q == wm1) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        ST_COPY_END, ST_PASS_END: begin
          if (state_q == ST_PASS_END && final_q) begin
            state_q <= ST_S_PUSH;
          end else if (state_q == ST_PASS_END && sts_i.sum_below) begin
            last_iter_q <= iter_n[ITER_W-1:0];
            final_q     <= 1'b1;
            state_q     <= ST_ISSUE;
          end else if (state_q == ST_COPY_END && do_check) begin
            res_pass_q <= 1'b1;
            final_q    <= 1'b0;
            state_q    <= ST_ISSUE;
          end else begin
            // next sweep, or the final residual after the last one
            iter_q     <= iter_n[ITER_W-1:0];
            chk_q      <= chk_n[ITER_W-1:0];
            res_pass_q <= !(iter_n < {1'b0, cfg_i.max_iter});
            final_q    <= 1'b1;
            state_q    <= ST_ISSUE;
          end
        end
        ST_S_PUSH: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/jss_dp.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil solver datapath
// Cell stores, stencil multiply-accumulate, Jacobi update via the divider,
// squared residual sum, solve status and the output register.
// ----------------------------------------------------------------------------
`include "jacobi_stencil_solver_core_defines.svh"

module jss_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jss_pkg::cfg_t                     cfg_i,
  input  jss_pkg::dp_cmd_t                  cmd_i,
  output jss_pkg::dp_sts_t                  sts_o,
  input  logic signed [jss_pkg::DATA_W-1:0] coef_center_i,
  input  logic signed [jss_pkg::DATA_W-1:0] coef_right_i,
  input  logic signed [jss_pkg::DATA_W-1:0] coef_up_i,
  input  logic signed [jss_pkg::DATA_W-1:0] rhs_value_i,
  input  logic signed [jss_pkg::DATA_W-1:0] start_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [jss_pkg::DATA_W-1:0] cell_value_o,
  output logic        [jss_pkg::ITER_W-1:0] iterations_used_o,
  output logic        [jss_pkg::RES_W-1:0]  residual_squared_o,
  output logic                              converged_o,
  output logic                              zero_diagonal_o
);
  import jss_pkg::*;

  localparam logic signed [ACC_W-1:0] NUM_LIM = ACC_W'(64'sd1 <<< (ACC_W - 2 - FRAC_BITS));

  logic [DATA_W-1:0] center_mem [CELLS];
  logic [DATA_W-1:0] right_mem  [CELLS];
  logic [DATA_W-1:0] up_mem     [CELLS];
  logic [DATA_W-1:0] rhs_mem    [CELLS];
  logic [DATA_W-1:0] sol_mem    [CELLS];
  logic [DATA_W-1:0] scr_mem    [CELLS];

  logic [IDX_W-1:0] right_addr, up_addr, sol_addr, copy_idx_q;
  logic signed [DATA_W-1:0] center_rd_q, right_rd_q, up_rd_q, rhs_rd_q, sol_rd_q, scr_rd_q;
  logic signed [DATA_W-1:0] coef_sel, rhs_c_q, ctr_c_q;
  phase_e            ph1_q, ph2_q;
  logic              en1_q, en2_q, copy_wr_q;
  logic signed [ACC_W-1:0] prod_d, prod_q, prod_sh, acc_q, cprod_q;
  logic signed [ACC_W-1:0] num, num_cl, num_sc, res;
  logic [ACC_W-1:0]  res_mag, sq_d, sq_q;
  logic              big_q;
  logic [RES_W-1:0]  sum_q, last_res_q;
  logic              zero_seen_q, out_valid_q, push;
  logic              div_busy, div_done, div_zero;
  logic [DATA_W-1:0] div_quo;

  // operand addresses per stencil phase
  always_comb begin
    right_addr = cmd_i.idx;
    up_addr    = cmd_i.idx;
    sol_addr   = cmd_i.idx;
    unique case (cmd_i.phase)
      PH_LEFT: begin
        right_addr = cmd_i.idx - 1'b1;
        sol_addr   = cmd_i.idx - 1'b1;
      end
      PH_RIGHT: sol_addr = cmd_i.idx + 1'b1;
      PH_DOWN: begin
        up_addr  = cmd_i.idx - IDX_W'(MAX_WIDTH);
        sol_addr = cmd_i.idx - IDX_W'(MAX_WIDTH);
      end
      PH_UP:   sol_addr = cmd_i.idx + IDX_W'(MAX_WIDTH);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      center_mem[cmd_i.ld_idx] <= coef_center_i;
      right_mem[cmd_i.ld_idx]  <= coef_right_i;
      up_mem[cmd_i.ld_idx]     <= coef_up_i;
      rhs_mem[cmd_i.ld_idx]    <= rhs_value_i;
    end
    center_rd_q <= center_mem[cmd_i.idx];
    rhs_rd_q    <= rhs_mem[cmd_i.idx];
    right_rd_q  <= right_mem[right_addr];
    up_rd_q     <= up_mem[up_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      sol_mem[cmd_i.ld_idx] <= start_value_i;
    end else if (copy_wr_q) begin
      sol_mem[copy_idx_q] <= scr_rd_q;
    end
    sol_rd_q <= sol_mem[sol_addr];
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      scr_mem[cmd_i.idx] <= div_quo;
    end
    scr_rd_q <= scr_mem[cmd_i.idx];
  end

  // multiply stage
  always_comb begin
    unique case (ph1_q)
      PH_CENTER:        coef_sel = center_rd_q;
      PH_LEFT, PH_RIGHT: coef_sel = right_rd_q;
      default:          coef_sel = up_rd_q;
    endcase
  end

  assign prod_d  = coef_sel * sol_rd_q;
  assign prod_sh = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q     <= PH_CENTER;
      ph2_q     <= PH_CENTER;
      en1_q     <= 1'b0;
      en2_q     <= 1'b0;
      copy_wr_q <= 1'b0;
    end else begin
      ph1_q     <= cmd_i.phase;
      en1_q     <= cmd_i.issue && cmd_i.nb_en;
      ph2_q     <= ph1_q;
      en2_q     <= en1_q;
      copy_wr_q <= cmd_i.copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_idx_q <= cmd_i.idx;
    prod_q     <= prod_d;
    if (en1_q && ph1_q == PH_CENTER) begin
      rhs_c_q <= rhs_rd_q;
      ctr_c_q <= center_rd_q;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (en2_q && ph2_q != PH_CENTER) begin
      acc_q <= acc_q + prod_sh;
    end
    if (en2_q && ph2_q == PH_CENTER) begin
      cprod_q <= prod_sh;
    end
  end

  // Jacobi numerator: clamp, then scale up by the fraction
  always_comb begin
    num = ACC_W'(rhs_c_q) - acc_q;
    if (num > NUM_LIM) begin
      num_cl = NUM_LIM;
    end else if (num < -NUM_LIM) begin
      num_cl = -NUM_LIM;
    end else begin
      num_cl = num;
    end
    num_sc = num_cl <<< FRAC_BITS;
  end

  jss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (num_sc),
    .dvs_i   (ctr_c_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .zero_o  (div_zero)
  );

  // residual b - A x of the current cell
  assign res     = ACC_W'(rhs_c_q) - (cprod_q + acc_q);
  assign res_mag = res[ACC_W-1] ? ACC_W'(-res) : ACC_W'(res);
  assign sq_d    = res_mag[DATA_W-1:0] * res_mag[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_sq) begin
      sq_q  <= sq_d;
      big_q <= |res_mag[ACC_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      last_res_q  <= MAX63;
      zero_seen_q <= 1'b0;
    end else begin
      if (cmd_i.sum_clr) begin
        sum_q <= '0;
      end else if (cmd_i.res_add) begin
        if (big_q || sq_q > {1'b0, MAX63 - sum_q}) begin
          sum_q <= MAX63;
        end else begin
          sum_q <= sum_q + sq_q[RES_W-1:0];
        end
      end
      if (cmd_i.res_we) begin
        last_res_q <= sum_q;
      end
      if (cmd_i.zero_clr) begin
        zero_seen_q <= 1'b0;
      end else if (div_done && div_zero) begin
        zero_seen_q <= 1'b1;
      end
    end
  end

  // output register
  assign push = cmd_i.push_rd || cmd_i.push_solve;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cell_value_o       <= (cmd_i.push_rd && cmd_i.rd_inside) ? sol_rd_q : '0;
      iterations_used_o  <= cmd_i.last_iter;
      residual_squared_o <= last_res_q;
      converged_o        <= last_res_q < cfg_i.tol;
      zero_diagonal_o    <= zero_seen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.sum_below = sum_q < cfg_i.tol;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  `JSS_ASSERT_NEVER(a_push_into_full, push && out_valid_q && !out_ready_i)
  `JSS_ASSERT_NEVER(a_sol_write_clash, cmd_i.load_we && copy_wr_q)
  `JSS_ASSERT_NEXT(a_div_runs, cmd_i.div_start, div_busy || div_done)

endmodule

[src/jacobi_stencil_solver_core.sv]
// ----------------------------------------------------------------------------
// Jacobi stencil solver core
// Sequencing: a load writes the stores on accept; a read fetches the cell and
//   pushes it once the output register is free; a solve reads each cell's
//   stencil operands and divides, copies the sweep, and runs residual passes.
// Throughput: one item at a time; the output register frees intake early.
// Reset (rst_ni, async low): control and config registers to defaults,
//   status reset, stores left unwritten (no clearing pass), output empty.
// ----------------------------------------------------------------------------
//
// Solves A x = b on a grid of up to 32x32 cells with a five-point symmetric
// stencil, Q16.16 arithmetic. Items:
//   load  - writes center/right/up coefficients, right side and start guess
//   solve - runs Jacobi sweeps up to max_iterations, with residual checks
//           every check_interval sweeps (first sweep excluded), then stores
//           the final squared residual; one result item
//   read  - returns one solution cell plus the last solve status
//
// Structure: jss_ctrl walks the grid and sequences passes; jss_dp holds the
// six cell stores, the stencil MAC pipeline (address, read, multiply,
// accumulate), the residual sum and the output register; jss_div produces
// one Jacobi quotient bit per cycle. A sweep writes a scratch store and is
// copied into the solution store once all cells are done, so every cell sees
// the previous sweep's values.
//
// Configuration: APB-style, 64-bit data, register i at byte address 8*i:
//   0 max_iterations, 1 check_interval, 2 tolerance_squared, 3 grid_width,
//   4 grid_height. Written by the user only while idle, unchecked by the core.
module jacobi_stencil_solver_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jss_pkg::ADDR_W-1:0]         paddr,
  input  logic [jss_pkg::PDATA_W-1:0]        pwdata,
  output logic [jss_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [4:0]                         col_i,
  input  logic [4:0]                         row_i,
  input  logic signed [jss_pkg::DATA_W-1:0]  coef_center_i,
  input  logic signed [jss_pkg::DATA_W-1:0]  coef_right_i,
  input  logic signed [jss_pkg::DATA_W-1:0]  coef_up_i,
  input  logic signed [jss_pkg::DATA_W-1:0]  rhs_value_i,
  input  logic signed [jss_pkg::DATA_W-1:0]  start_value_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [jss_pkg::DATA_W-1:0]  cell_value_o,
  output logic [jss_pkg::ITER_W-1:0]         iterations_used_o,
  output logic [jss_pkg::RES_W-1:0]          residual_squared_o,
  output logic                               converged_o,
  output logic                               zero_diagonal_o
);
  import jss_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;
  logic       cfg_we;
  logic [2:0] reg_idx;

  // register file; a write lands on the access cycle
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter <= ITER_W'(100);
      cfg_q.chk_int  <= ITER_W'(10);
      cfg_q.tol      <= RES_W'(4294967);
      cfg_q.grid_w   <= GRID_W'(MAX_WIDTH);
      cfg_q.grid_h   <= GRID_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MAX_ITER: cfg_q.max_iter <= pwdata[ITER_W-1:0];
        REG_CHK_INT:  cfg_q.chk_int  <= pwdata[ITER_W-1:0];
        REG_TOL:      cfg_q.tol      <= pwdata[RES_W-1:0];
        REG_GRID_W:   cfg_q.grid_w   <= pwdata[GRID_W-1:0];
        REG_GRID_H:   cfg_q.grid_h   <= pwdata[GRID_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_ITER: prdata = PDATA_W'(cfg_q.max_iter);
      REG_CHK_INT:  prdata = PDATA_W'(cfg_q.chk_int);
      REG_TOL:      prdata = PDATA_W'(cfg_q.tol);
      REG_GRID_W:   prdata = PDATA_W'(cfg_q.grid_w);
      REG_GRID_H:   prdata = PDATA_W'(cfg_q.grid_h);
      default:      prdata = '0;
    endcase
  end

  jss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  jss_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (dp_cmd),
    .sts_o              (dp_sts),
    .coef_center_i      (coef_center_i),
    .coef_right_i       (coef_right_i),
    .coef_up_i          (coef_up_i),
    .rhs_value_i        (rhs_value_i),
    .start_value_i      (start_value_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .cell_value_o       (cell_value_o),
    .iterations_used_o  (iterations_used_o),
    .residual_squared_o (residual_squared_o),
    .converged_o        (converged_o),
    .zero_diagonal_o    (zero_diagonal_o)
  );

endmodule
